>>> src/gradient_noise_3d_top_defines.svh
// assertion macros for the gradient noise block
// expects clk and rst_n in the scope of every use
`ifndef GRADIENT_NOISE_3D_TOP_DEFINES_SVH
`define GRADIENT_NOISE_3D_TOP_DEFINES_SVH

// same-cycle implication
`define GN3D_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

// next-cycle implication
`define GN3D_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

>>> src/gn3d_pkg.sv
// shared types and constants of the gradient noise block
// no dependencies
package gn3d_pkg;

  localparam int FRAC_W  = 16;
  localparam int FADE_W  = 17;
  localparam int POLY_W  = 20;
  localparam int MUL_W   = 24;
  localparam int PROD_W  = 48;
  localparam int DOT_W   = 34;
  localparam int DIFF_W  = 35;
  localparam int LO_W    = 17;
  localparam int HI_W    = 18;
  localparam int FULL_W  = 52;
  localparam int OUT_W   = 16;
  localparam int STEP_W  = 3;

  localparam logic OPC_WRITE = 1'b0;
  localparam logic OPC_EVAL  = 1'b1;

  localparam logic [FADE_W-1:0] FADE_ONE = FADE_W'(65536);
  localparam logic [POLY_W-1:0] FADE_K15 = POLY_W'(15 * 65536);
  localparam logic [POLY_W-1:0] FADE_K10 = POLY_W'(10 * 65536);

  // fade sub-steps
  localparam logic [STEP_W-1:0] FADE_SQ    = 3'd0;
  localparam logic [STEP_W-1:0] FADE_CUBE  = 3'd1;
  localparam logic [STEP_W-1:0] FADE_POLY  = 3'd2;
  localparam logic [STEP_W-1:0] FADE_BLEND = 3'd3;
  localparam logic [STEP_W-1:0] FADE_DONE  = 3'd4;
  // dot product sub-steps
  localparam logic [STEP_W-1:0] DOT_READ = 3'd0;
  localparam logic [STEP_W-1:0] DOT_MX   = 3'd1;
  localparam logic [STEP_W-1:0] DOT_MY   = 3'd2;
  localparam logic [STEP_W-1:0] DOT_MZ   = 3'd3;
  localparam logic [STEP_W-1:0] DOT_SUM  = 3'd4;
  // interpolation sub-steps
  localparam logic [STEP_W-1:0] LERP_LO   = 3'd0;
  localparam logic [STEP_W-1:0] LERP_HI   = 3'd1;
  localparam logic [STEP_W-1:0] LERP_PUSH = 3'd2;

  localparam logic [STEP_W-1:0] AXIS_LAST   = 3'd2;
  localparam logic [STEP_W-1:0] CORNER_LAST = 3'd7;
  localparam logic [STEP_W-1:0] LERP_LAST   = 3'd6;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_WRITE,
    OP_LOAD,
    OP_FADE,
    OP_DOT,
    OP_LERP,
    OP_FINISH
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [STEP_W-1:0] idx;
    logic [STEP_W-1:0] sub;
  } cmd_t;

endpackage

>>> src/gn3d_ctrl.sv
// sequencer of the gradient noise block: fade, corner dots, interpolation
// depends on gn3d_pkg and gradient_noise_3d_top_defines.svh
`include "gradient_noise_3d_top_defines.svh"

module gn3d_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_opcode,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  output gn3d_pkg::cmd_t  cmd
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_FADE = 5'b00010,
    ST_DOT  = 5'b00100,
    ST_LERP = 5'b01000,
    ST_FIN  = 5'b10000
  } state_t;

  state_t                      state_r, state_nxt;
  logic [gn3d_pkg::STEP_W-1:0] idx_r, idx_nxt;
  logic [gn3d_pkg::STEP_W-1:0] sub_r, sub_nxt;
  logic                        out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    sub_nxt       = sub_r;
    out_valid_nxt = out_valid_r & out_stall;
    cmd.op        = gn3d_pkg::OP_NONE;
    cmd.idx       = idx_r;
    cmd.sub       = sub_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_opcode == gn3d_pkg::OPC_EVAL) begin
            cmd.op    = gn3d_pkg::OP_LOAD;
            state_nxt = ST_FADE;
            idx_nxt   = '0;
            sub_nxt   = '0;
          end else begin
            cmd.op = gn3d_pkg::OP_WRITE;
          end
        end
      end
      ST_FADE: begin
        cmd.op = gn3d_pkg::OP_FADE;
        if (sub_r == gn3d_pkg::FADE_DONE) begin
          sub_nxt = '0;
          if (idx_r == gn3d_pkg::AXIS_LAST) begin
            idx_nxt   = '0;
            state_nxt = ST_DOT;
          end else begin
            idx_nxt = idx_r + 3'd1;
          end
        end else begin
          sub_nxt = sub_r + 3'd1;
        end
      end
      ST_DOT: begin
        cmd.op = gn3d_pkg::OP_DOT;
        if (sub_r == gn3d_pkg::DOT_SUM) begin
          sub_nxt = '0;
          if (idx_r == gn3d_pkg::CORNER_LAST) begin
            idx_nxt   = '0;
            state_nxt = ST_LERP;
          end else begin
            idx_nxt = idx_r + 3'd1;
          end
        end else begin
          sub_nxt = sub_r + 3'd1;
        end
      end
      ST_LERP: begin
        cmd.op = gn3d_pkg::OP_LERP;
        if (sub_r == gn3d_pkg::LERP_PUSH) begin
          sub_nxt = '0;
          if (idx_r == gn3d_pkg::LERP_LAST) begin
            idx_nxt   = '0;
            state_nxt = ST_FIN;
          end else begin
            idx_nxt = idx_r + 3'd1;
          end
        end else begin
          sub_nxt = sub_r + 3'd1;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || !out_stall) begin
          cmd.op        = gn3d_pkg::OP_FINISH;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      sub_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      sub_r       <= sub_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  `GN3D_ASSERT_NEXT(a_eval_starts_fade, state_r == ST_IDLE && in_valid && in_opcode == gn3d_pkg::OPC_EVAL, state_r == ST_FADE && idx_r == '0 && sub_r == '0, "evaluate beat did not start the fade")
  `GN3D_ASSERT_NEXT(a_dot_follows_fade, state_r == ST_FADE && sub_r == gn3d_pkg::FADE_DONE && idx_r == gn3d_pkg::AXIS_LAST, state_r == ST_DOT && idx_r == '0, "corner pass did not follow the fade")
  `GN3D_ASSERT_NEXT(a_finish_shows_result, cmd.op == gn3d_pkg::OP_FINISH, out_valid_r, "finished result not presented")

endmodule

>>> src/gn3d_datapath.sv
// datapath of the gradient noise block: gradient memory, shared multiplier,
// fade, corner dots, interpolation queue and output register; uses gn3d_pkg
module gn3d_datapath #(
  parameter int GRID_CELLS = 16
) (
  input  logic                                 clk,
  input  gn3d_pkg::cmd_t                       cmd,
  input  logic [4:0]                           in_lattice_i,
  input  logic [4:0]                           in_lattice_j,
  input  logic [4:0]                           in_lattice_k,
  input  logic signed [15:0]                   in_grad_x,
  input  logic signed [15:0]                   in_grad_y,
  input  logic signed [15:0]                   in_grad_z,
  input  logic [15:0]                          in_point_x,
  input  logic [15:0]                          in_point_y,
  input  logic [15:0]                          in_point_z,
  output logic signed [gn3d_pkg::OUT_W-1:0]    out_noise_value
);

  localparam int SIDE  = GRID_CELLS + 1;
  localparam int DEPTH = SIDE * SIDE * SIDE;
  localparam int AW    = $clog2(DEPTH);
  localparam int IW    = $clog2(SIDE);
  localparam int SW    = gn3d_pkg::FRAC_W + IW;
  localparam int MW    = gn3d_pkg::MUL_W;
  localparam int DW    = gn3d_pkg::DOT_W;

  logic [47:0]                      mem_r [DEPTH];
  logic [47:0]                      rd_r;
  logic [IW-1:0]                    cell_r [3];
  logic [gn3d_pkg::FRAC_W-1:0]      frac_r [3];
  logic [gn3d_pkg::FADE_W-1:0]      fade_r [3];
  logic [gn3d_pkg::FRAC_W-1:0]      t3_r;
  logic signed [DW-1:0]             acc_r;
  logic [gn3d_pkg::DIFF_W-1:0]      plo_r;
  logic signed [DW-1:0]             lv_r [8];
  logic signed [gn3d_pkg::PROD_W-1:0] prod_r;
  logic signed [gn3d_pkg::OUT_W-1:0]  out_r;

  logic [15:0]                      pt [3];
  logic [SW-1:0]                    scaled [3];
  logic                             wr_ok;
  logic [AW-1:0]                    waddr, raddr;
  logic [IW-1:0]                    ci, cj, ck;
  logic [gn3d_pkg::FRAC_W-1:0]      f;
  logic [gn3d_pkg::POLY_W-1:0]      q16, poly, blend;
  logic [1:0]                       axis;
  logic [gn3d_pkg::FADE_W-1:0]      u;
  logic signed [17:0]               dx, dy, dz;
  logic signed [gn3d_pkg::DIFF_W-1:0] diff;
  logic [gn3d_pkg::LO_W-1:0]        lo;
  logic signed [gn3d_pkg::HI_W-1:0] hi;
  logic signed [gn3d_pkg::FULL_W-1:0] full;
  logic signed [DW+1:0]             lerp_res;
  logic signed [DW:0]               rnd;
  logic signed [DW-16:0]            rq;
  logic signed [MW-1:0]             mul_a, mul_b;

  assign pt[0] = in_point_x;
  assign pt[1] = in_point_y;
  assign pt[2] = in_point_z;

  always_comb begin
    for (int n = 0; n < 3; n++) begin
      scaled[n] = SW'(pt[n]) * SW'(GRID_CELLS);
    end
  end

  // write address, range checked against the lattice side
  assign wr_ok = (int'(in_lattice_i) <= GRID_CELLS) && (int'(in_lattice_j) <= GRID_CELLS) &&
                 (int'(in_lattice_k) <= GRID_CELLS);
  assign waddr = (AW'(in_lattice_i) * AW'(SIDE) + AW'(in_lattice_j)) * AW'(SIDE) +
                 AW'(in_lattice_k);

  // corner address from cell and corner bits
  assign ci    = cell_r[0] + IW'(cmd.idx[0]);
  assign cj    = cell_r[1] + IW'(cmd.idx[1]);
  assign ck    = cell_r[2] + IW'(cmd.idx[2]);
  assign raddr = (AW'(ci) * AW'(SIDE) + AW'(cj)) * AW'(SIDE) + AW'(ck);

  // fade terms
  assign f     = frac_r[cmd.idx[1:0]];
  assign q16   = prod_r[35:16];
  assign poly  = gn3d_pkg::FADE_K15 - ((gn3d_pkg::POLY_W'(f) << 2) +
                                       (gn3d_pkg::POLY_W'(f) << 1));
  assign blend = gn3d_pkg::FADE_K10 - q16;

  // corner offsets
  assign dx = $signed({2'b00, frac_r[0]}) - (cmd.idx[0] ? 18'sh10000 : 18'sh0);
  assign dy = $signed({2'b00, frac_r[1]}) - (cmd.idx[1] ? 18'sh10000 : 18'sh0);
  assign dz = $signed({2'b00, frac_r[2]}) - (cmd.idx[2] ? 18'sh10000 : 18'sh0);

  // interpolation: four along x, two along y, one along z
  assign axis     = (cmd.idx < 3'd4) ? 2'd0 : ((cmd.idx < 3'd6) ? 2'd1 : 2'd2);
  assign u        = fade_r[axis];
  assign diff     = gn3d_pkg::DIFF_W'(lv_r[1]) - gn3d_pkg::DIFF_W'(lv_r[0]);
  assign lo       = diff[gn3d_pkg::LO_W-1:0];
  assign hi       = diff[gn3d_pkg::DIFF_W-1:gn3d_pkg::LO_W];
  assign full     = $signed({prod_r[34:0], 17'b0}) + $signed({17'b0, plo_r});
  assign lerp_res = (DW+2)'(lv_r[0]) + full[gn3d_pkg::FULL_W-1:16];

  // round half up to q2.14
  assign rnd = (DW+1)'(lv_r[0]) + (DW+1)'(32768);
  assign rq  = rnd[DW:16];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.op)
      gn3d_pkg::OP_FADE: begin
        unique case (cmd.sub)
          gn3d_pkg::FADE_SQ: begin
            mul_a = MW'(f);
            mul_b = MW'(f);
          end
          gn3d_pkg::FADE_CUBE: begin
            mul_a = MW'(prod_r[31:16]);
            mul_b = MW'(f);
          end
          gn3d_pkg::FADE_POLY: begin
            mul_a = MW'(poly);
            mul_b = MW'(f);
          end
          gn3d_pkg::FADE_BLEND: begin
            mul_a = MW'(t3_r);
            mul_b = MW'(blend);
          end
          default: begin
            mul_a = '0;
            mul_b = '0;
          end
        endcase
      end
      gn3d_pkg::OP_DOT: begin
        unique case (cmd.sub)
          gn3d_pkg::DOT_MX: begin
            mul_a = MW'($signed(rd_r[47:32]));
            mul_b = MW'(dx);
          end
          gn3d_pkg::DOT_MY: begin
            mul_a = MW'($signed(rd_r[31:16]));
            mul_b = MW'(dy);
          end
          gn3d_pkg::DOT_MZ: begin
            mul_a = MW'($signed(rd_r[15:0]));
            mul_b = MW'(dz);
          end
          default: begin
            mul_a = '0;
            mul_b = '0;
          end
        endcase
      end
      gn3d_pkg::OP_LERP: begin
        unique case (cmd.sub)
          gn3d_pkg::LERP_LO: begin
            mul_a = MW'(lo);
            mul_b = MW'(u);
          end
          gn3d_pkg::LERP_HI: begin
            mul_a = MW'(hi);
            mul_b = MW'(u);
          end
          default: begin
            mul_a = '0;
            mul_b = '0;
          end
        endcase
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  // gradient memory
  always_ff @(posedge clk) begin
    if (cmd.op == gn3d_pkg::OP_WRITE && wr_ok) begin
      mem_r[waddr] <= {in_grad_x, in_grad_y, in_grad_z};
    end
    if (cmd.op == gn3d_pkg::OP_DOT && cmd.sub == gn3d_pkg::DOT_READ) begin
      rd_r <= mem_r[raddr];
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      gn3d_pkg::OP_LOAD: begin
        for (int n = 0; n < 3; n++) begin
          cell_r[n] <= scaled[n][SW-1:gn3d_pkg::FRAC_W];
          frac_r[n] <= scaled[n][gn3d_pkg::FRAC_W-1:0];
        end
      end
      gn3d_pkg::OP_FADE: begin
        if (cmd.sub == gn3d_pkg::FADE_POLY) begin
          t3_r <= prod_r[31:16];
        end
        if (cmd.sub == gn3d_pkg::FADE_DONE) begin
          fade_r[cmd.idx[1:0]] <= (q16 > gn3d_pkg::POLY_W'(gn3d_pkg::FADE_ONE)) ?
                                  gn3d_pkg::FADE_ONE : q16[gn3d_pkg::FADE_W-1:0];
        end
      end
      gn3d_pkg::OP_DOT: begin
        if (cmd.sub == gn3d_pkg::DOT_MY) begin
          acc_r <= DW'(prod_r);
        end
        if (cmd.sub == gn3d_pkg::DOT_MZ) begin
          acc_r <= acc_r + DW'(prod_r);
        end
        if (cmd.sub == gn3d_pkg::DOT_SUM) begin
          lv_r[cmd.idx] <= acc_r + DW'(prod_r);
        end
      end
      gn3d_pkg::OP_LERP: begin
        if (cmd.sub == gn3d_pkg::LERP_HI) begin
          plo_r <= prod_r[34:0];
        end
        if (cmd.sub == gn3d_pkg::LERP_PUSH) begin
          // shift the queue by two, the new value lands in its own slot
          for (int n = 0; n < 6; n++) begin
            lv_r[n] <= (gn3d_pkg::LERP_LAST - cmd.idx == gn3d_pkg::STEP_W'(n)) ?
                       lerp_res[DW-1:0] : lv_r[n+2];
          end
          if (cmd.idx == '0) begin
            lv_r[gn3d_pkg::LERP_LAST] <= lerp_res[DW-1:0];
          end
        end
      end
      gn3d_pkg::OP_FINISH: begin
        if (rq > (DW-15)'(32767)) begin
          out_r <= 16'sh7fff;
        end else if (rq < -(DW-15)'(32768)) begin
          out_r <= 16'sh8000;
        end else begin
          out_r <= rq[gn3d_pkg::OUT_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  assign out_noise_value = out_r;

endmodule

>>> src/gradient_noise_3d_top.sv
// top level of the 3d gradient noise block
// instantiates gn3d_ctrl and gn3d_datapath; uses gn3d_pkg
//
// usage
// - input channel (in_valid / in_stall): each beat is a gradient write
//   (in_opcode 0) or a noise evaluation (in_opcode 1)
// - a write stores one gradient at lattice point (i, j, k) and
//   gives no result; writes with any index above GRID_CELLS are dropped
// - an evaluation gives one out_noise_value beat, q2.14, saturated
// - an evaluation runs 3 fade axes of 5 steps, 8 corners of 5 steps and
//   7 interpolations of 3 steps, all on the one shared 24x24 multiplier,
//   plus the finish step; the next evaluation is not taken before it is done
// - throughput: one write per cycle while no evaluation is in flight
// - in_stall is high while an evaluation is in flight
// - the result sits in an output register; a stalled result holds and the
//   next beat is still taken behind it; a new result waits for room
// - reset (rst_n low, synchronous) clears the sequencer and output valid;
//   the gradient memory is not cleared, every entry read must be written
module gradient_noise_3d_top #(
  parameter int GRID_CELLS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_opcode,
  input  logic [4:0]         in_lattice_i,
  input  logic [4:0]         in_lattice_j,
  input  logic [4:0]         in_lattice_k,
  input  logic signed [15:0] in_grad_x,
  input  logic signed [15:0] in_grad_y,
  input  logic signed [15:0] in_grad_z,
  input  logic [15:0]        in_point_x,
  input  logic [15:0]        in_point_y,
  input  logic [15:0]        in_point_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_noise_value
);

  // command word from sequencer to datapath
  gn3d_pkg::cmd_t cmd;

  gn3d_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_opcode),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  gn3d_datapath #(
    .GRID_CELLS (GRID_CELLS)
  ) u_datapath (
    .clk             (clk),
    .cmd             (cmd),
    .in_lattice_i    (in_lattice_i),
    .in_lattice_j    (in_lattice_j),
    .in_lattice_k    (in_lattice_k),
    .in_grad_x       (in_grad_x),
    .in_grad_y       (in_grad_y),
    .in_grad_z       (in_grad_z),
    .in_point_x      (in_point_x),
    .in_point_y      (in_point_y),
    .in_point_z      (in_point_z),
    .out_noise_value (out_noise_value)
  );

endmodule
